// ----- rtl/signed_int_to_decimal_ascii_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
// Implication checked on every edge outside reset.
`define SIDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SIDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/sida_pkg.sv -----
package sida_pkg;
    localparam int unsigned ValW   = 32;
    localparam int unsigned NDig   = 10;
    localparam int unsigned BcdW   = 4 * NDig;
    // Binary bits consumed per pipeline stage
    localparam int unsigned BitsPerStg = 4;
    localparam int unsigned NStg   = ValW / BitsPerStg;
    localparam logic [7:0] ChMinus = 8'd45;
    localparam logic [7:0] ChZero  = 8'd48;

    typedef struct packed {
        logic [ValW-1:0] bin;
        logic [BcdW-1:0] bcd;
        logic            neg;
    } t_conv;

    // One step of shift-add-3: add 3 to digits >= 5, then shift in one bit.
    function automatic logic [BcdW-1:0] dd_step(input logic [BcdW-1:0] b,
                                                input logic bit_in);
        logic [BcdW-1:0] t;
        t = b;
        for (int d = 0; d < NDig; d++) begin
            if (t[4*d +: 4] >= 4'd5) begin
                t[4*d +: 4] = t[4*d +: 4] + 4'd3;
            end
        end
        return {t[BcdW-2:0], bit_in};
    endfunction
endpackage

// ----- rtl/sida_stream_if.sv -----
interface sida_stream_if #(parameter int unsigned W = 8) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sida_bcd_pipe.sv -----
`include "signed_int_to_decimal_ascii_assert.svh"
module sida_bcd_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sida_pkg::t_conv       i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sida_pkg::t_conv       o_data
);
    logic [sida_pkg::NStg-1:0] r_vld;
    sida_pkg::t_conv           r_stg [sida_pkg::NStg];
    logic [sida_pkg::NStg-1:0] w_adv;

    // Stage s may load when it is empty or its contents move on.
    always_comb begin
        w_adv[sida_pkg::NStg-1] = !r_vld[sida_pkg::NStg-1] || i_ready;
        for (int s = sida_pkg::NStg - 2; s >= 0; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[sida_pkg::NStg-1];
    assign o_data  = r_stg[sida_pkg::NStg-1];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < sida_pkg::NStg; s++) begin
            if (w_adv[s]) begin
                sida_pkg::t_conv src;
                logic            v;
                src = (s == 0) ? i_data : r_stg[(s == 0) ? 0 : s-1];
                v   = (s == 0) ? i_valid : r_vld[(s == 0) ? 0 : s-1];
                for (int k = 0; k < sida_pkg::BitsPerStg; k++) begin
                    src.bcd = sida_pkg::dd_step(src.bcd, src.bin[sida_pkg::ValW-1]);
                    src.bin = {src.bin[sida_pkg::ValW-2:0], 1'b0};
                end
                r_stg[s] <= src;
                if (!i_rst_n) r_vld[s] <= 1'b0;
                else          r_vld[s] <= v;
            end else if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end
        end
    end

    `SIDA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `SIDA_ASSERT_IMP(a_bcd_ok, i_clk, i_rst_n, o_valid, o_data.bcd[39:36] <= 4'd4)
endmodule

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// Signed 32-bit to decimal ASCII. One two's complement value per input
// transfer; its text leaves as one character per output transfer, most
// significant first, '-' ahead of negatives, no leading zeros, '0' for zero,
// last_char set on the final character. An 8-stage double-dabble pipeline
// (four shift-add-3 steps per stage) takes a new value every cycle while
// its output is not stalled. The character emitter then sends one
// character per cycle while the output is ready; a value's text is 1 to 11
// characters, which sets the sustained rate. The emitter takes the next
// value in the same cycle its final character transfers.
`include "signed_int_to_decimal_ascii_assert.svh"
module signed_int_to_decimal_ascii (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sida_stream_if.sink   i_value,
    sida_stream_if.source o_char
);
    sida_pkg::t_conv w_in, w_pout;
    logic            w_pvld, w_prdy;

    // Magnitude formed as unsigned; most negative value stays 2^31.
    always_comb begin
        w_in.neg = i_value.data[31];
        w_in.bin = i_value.data[31] ? (32'd0 - i_value.data[31:0]) : i_value.data[31:0];
        w_in.bcd = '0;
    end

    sida_bcd_pipe u_pipe (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_value.valid), .o_ready(i_value.ready), .i_data(w_in),
        .o_valid(w_pvld), .i_ready(w_prdy), .o_data(w_pout)
    );

    // Emitter: holds digits, sign flag and a digit index.
    logic                        r_busy, n_busy;
    logic [sida_pkg::BcdW-1:0]   r_bcd, n_bcd;
    logic                        r_sign, n_sign;
    logic [3:0]                  r_idx, n_idx;
    logic [3:0]                  w_top;
    logic                        w_last, w_fire;

    // Index of the highest non-zero digit (0 for zero).
    always_comb begin
        w_top = 4'd0;
        for (int d = 0; d < sida_pkg::NDig; d++) begin
            if (w_pout.bcd[4*d +: 4] != 4'd0) w_top = 4'(d);
        end
    end

    assign w_fire = o_char.valid && o_char.ready;
    assign w_last = !r_sign && (r_idx == 4'd0);
    assign w_prdy = !r_busy || (w_fire && w_last);

    always_comb begin
        o_char.valid = r_busy;
        if (r_sign) o_char.data = {sida_pkg::ChMinus, 1'b0};
        else        o_char.data = {sida_pkg::ChZero + {4'd0, r_bcd[{r_idx, 2'b00} +: 4]},
                                   w_last};
    end

    always_comb begin
        n_busy = r_busy;
        n_bcd  = r_bcd;
        n_sign = r_sign;
        n_idx  = r_idx;
        if (w_fire) begin
            if (r_sign)      n_sign = 1'b0;
            else if (w_last) n_busy = 1'b0;
            else             n_idx  = r_idx - 4'd1;
        end
        if (w_pvld && w_prdy) begin
            n_busy = 1'b1;
            n_bcd  = w_pout.bcd;
            n_sign = w_pout.neg;
            n_idx  = w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_bcd  <= n_bcd;
        r_sign <= n_sign;
        r_idx  <= n_idx;
    end

    `SIDA_ASSERT_IMP(a_idx_rng, i_clk, i_rst_n, r_busy, r_idx <= 4'd9)
    `SIDA_ASSERT_NEXT(a_sign_first, i_clk, i_rst_n, w_fire && r_sign, r_busy && !r_sign)
    `SIDA_ASSERT_IMP(a_last_ch, i_clk, i_rst_n, w_fire && o_char.data[0], !r_sign)
endmodule
